@@ hw/rtl/editing_line_input_buffer_macros.svh @@
// assertion macros for the editing line input buffer checker
`ifndef EDITING_LINE_INPUT_BUFFER_MACROS_SVH
`define EDITING_LINE_INPUT_BUFFER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ELIB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("elib assertion failed");

// next-cycle implication, disabled while in reset
`define ELIB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("elib assertion failed");

`endif

@@ hw/rtl/elib_pkg.sv @@
// shared types and codes of the editing line input buffer
package elib_pkg;

    localparam int BYTE_W = 8;

    // result kinds
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // line end status
    localparam logic [1:0] ST_EOL    = 2'd0;
    localparam logic [1:0] ST_CANCEL = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // control characters
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_CAN   = 8'h18;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] LIMIT_RESET = 8'd80;

    // what a decoded request will produce
    typedef enum logic [2:0] {
        OP_READ,
        OP_BELL,
        OP_RUBOUT,
        OP_EOL,
        OP_CANCEL,
        OP_CHAR,
        OP_CHAR_FULL
    } op_t;

endpackage

@@ hw/rtl/elib_line_store.sv @@
// byte store of the current line, one write and one registered read port
module elib_line_store #(
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);
    import elib_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/editing_line_input_buffer.sv @@
// top level of the editing line input buffer
//
// s_axis carries requests: tuser 0 is a received byte (tdata[7:0]), tuser 1
// reads the line store at tdata[15:8]. m_axis returns results: tuser is the
// kind (echo, line ended, read data), tdata holds the byte, the end status and
// the line length, tlast marks the final result of a request.
// cfg_valid/cfg_data write the line limit; the port is always ready.
//
// a request is decoded and its state update and store write happen at the
// accepting edge; its first result passes the held-request register, then
// the output register. a single sequencer walks the results of one request,
// one per cycle unless m_axis stalls, so a request holds the input until its
// last result (one to three) goes out; one-result requests stream at one per
// cycle unless m_axis stalls. the store registers read data at acceptance.
// reset clears the count, length, line state and limit (80); the store
// content is undefined until written. when m_axis stalls the output register
// and the sequencer hold and s_axis_tready drops once both are occupied.
module editing_line_input_buffer #(
    parameter int STORE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // in_byte[7:0], read_index[15:8]
    input  logic        s_axis_tuser,   // func[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_byte[7:0], end_status[9:8],
                                        // line_length[17:10], zero[23:18]
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import elib_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    // line state
    logic [7:0] char_count_reg, char_count_next;
    logic [8:0] stored_length_reg, stored_length_next;
    logic       line_closed_reg, line_closed_next;
    logic [7:0] line_limit_reg;

    // decoded request held while its results go out
    logic       d_valid_reg;
    logic [1:0] d_step_reg;
    op_t        d_op_reg, op_dec;
    logic [7:0] d_byte_reg;
    logic [7:0] d_len_reg, len_dec;
    logic       d_rd_ok_reg, rd_ok_dec;

    // output register
    logic       o_valid_reg;
    logic [7:0] o_byte_reg;
    logic [1:0] o_kind_reg, o_status_reg;
    logic [7:0] o_len_reg;
    logic       o_last_reg;

    logic       acc, func;
    logic [7:0] in_byte, read_index, cc, cc_inc;
    logic       store_flag, wr_en, rd_en;
    logic [7:0] rd_data;

    logic       emit, fin;
    logic [1:0] res_kind, res_status;
    logic [7:0] res_byte, res_len;
    logic       res_last;

    assign func       = s_axis_tuser;
    assign in_byte    = s_axis_tdata[7:0];
    assign read_index = s_axis_tdata[15:8];
    assign acc        = s_axis_tvalid && s_axis_tready;

    // a closed line restarts on the next received byte
    assign cc     = line_closed_reg ? 8'd0 : char_count_reg;
    assign cc_inc = cc + 8'd1;

    always_comb
    begin
        char_count_next    = char_count_reg;
        stored_length_next = stored_length_reg;
        line_closed_next   = line_closed_reg;
        op_dec             = OP_READ;
        len_dec            = 8'd0;
        rd_ok_dec          = 1'b0;
        store_flag         = 1'b0;
        if (func)
        begin
            rd_ok_dec = (9'(read_index) < stored_length_reg)
                     && (32'(read_index) < STORE_DEPTH);
        end
        else
        begin
            line_closed_next   = 1'b0;
            char_count_next    = cc;
            stored_length_next = 9'(cc);
            if (in_byte inside {CH_BS, CH_DEL})
            begin
                if (cc == 8'd0)
                begin
                    op_dec = OP_BELL;
                end
                else
                begin
                    op_dec             = OP_RUBOUT;
                    char_count_next    = cc - 8'd1;
                    stored_length_next = 9'(cc - 8'd1);
                end
            end
            else if (in_byte inside {CH_CR, CH_LF})
            begin
                store_flag         = 1'b1;
                stored_length_next = 9'(cc) + 9'd1;
                line_closed_next   = 1'b1;
                op_dec             = OP_EOL;
                len_dec            = cc;
            end
            else if (in_byte == CH_CAN)
            begin
                char_count_next    = 8'd0;
                stored_length_next = 9'd0;
                line_closed_next   = 1'b1;
                op_dec             = OP_CANCEL;
            end
            else
            begin
                store_flag         = 1'b1;
                char_count_next    = cc_inc;
                stored_length_next = 9'(cc_inc);
                if (cc_inc >= line_limit_reg)
                begin
                    line_closed_next = 1'b1;
                    op_dec           = OP_CHAR_FULL;
                    len_dec          = cc_inc;
                end
                else
                begin
                    op_dec = OP_CHAR;
                end
            end
        end
    end

    // positions beyond the store are counted but not written
    assign wr_en = acc && !func && store_flag && (32'(cc) < STORE_DEPTH);
    assign rd_en = acc && func;

    elib_line_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (AW'(cc)),
        .wr_data (in_byte),
        .rd_en   (rd_en),
        .rd_addr (AW'(read_index)),
        .rd_data (rd_data)
    );

    // result selected by the held request and step
    always_comb
    begin
        res_kind   = KIND_ECHO;
        res_byte   = d_byte_reg;
        res_status = ST_EOL;
        res_len    = 8'd0;
        res_last   = 1'b1;
        case (d_op_reg)
            OP_READ:
            begin
                res_kind = KIND_READ;
                res_byte = d_rd_ok_reg ? rd_data : 8'd0;
            end
            OP_BELL:
            begin
                res_byte = CH_BEL;
            end
            OP_RUBOUT:
            begin
                res_byte = (d_step_reg == 2'd1) ? CH_SPACE : CH_BS;
                res_last = (d_step_reg == 2'd2);
            end
            OP_EOL:
            begin
                res_kind = KIND_END;
                res_len  = d_len_reg;
            end
            OP_CANCEL:
            begin
                res_kind   = KIND_END;
                res_status = ST_CANCEL;
            end
            OP_CHAR:
            begin
                res_kind = KIND_ECHO;
            end
            OP_CHAR_FULL:
            begin
                if (d_step_reg == 2'd0)
                begin
                    res_last = 1'b0;
                end
                else
                begin
                    res_kind   = KIND_END;
                    res_status = ST_FULL;
                    res_len    = d_len_reg;
                end
            end
            default:
            begin
                res_kind = KIND_ECHO;
            end
        endcase
    end

    assign emit          = d_valid_reg && (!o_valid_reg || m_axis_tready);
    assign fin           = emit && res_last;
    assign s_axis_tready = !d_valid_reg || fin;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg    <= 8'd0;
            stored_length_reg <= 9'd0;
            line_closed_reg   <= 1'b0;
            line_limit_reg    <= LIMIT_RESET;
            d_valid_reg       <= 1'b0;
            d_step_reg        <= 2'd0;
            o_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                line_limit_reg <= cfg_data;
            end
            if (acc)
            begin
                char_count_reg    <= char_count_next;
                stored_length_reg <= stored_length_next;
                line_closed_reg   <= line_closed_next;
            end
            if (acc)
            begin
                d_valid_reg <= 1'b1;
                d_step_reg  <= 2'd0;
            end
            else if (fin)
            begin
                d_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                d_step_reg <= d_step_reg + 2'd1;
            end
            if (emit)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            d_op_reg    <= op_dec;
            d_byte_reg  <= in_byte;
            d_len_reg   <= len_dec;
            d_rd_ok_reg <= rd_ok_dec;
        end
        if (emit)
        begin
            o_kind_reg   <= res_kind;
            o_byte_reg   <= res_byte;
            o_status_reg <= res_status;
            o_len_reg    <= res_len;
            o_last_reg   <= res_last;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {6'd0, o_len_reg, o_status_reg, o_byte_reg};
    assign m_axis_tuser  = o_kind_reg;
    assign m_axis_tlast  = o_last_reg;

endmodule

@@ hw/rtl/elib_checker.sv @@
// port checks of the editing line input buffer, bound to the top level
`include "editing_line_input_buffer_macros.svh"

module elib_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import elib_pkg::*;

    // a stalled result holds
    `ELIB_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
        && $stable(m_axis_tlast))

    // read data is always the only result of its request
    `ELIB_ASSERT_NOW(a_read_single, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == KIND_READ), m_axis_tlast)

    // a line end is always the final result of its request
    `ELIB_ASSERT_NOW(a_end_final, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == KIND_END), m_axis_tlast)

    // status and length are zero except on a line end
    `ELIB_ASSERT_NOW(a_fields_zero, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser != KIND_END), m_axis_tdata[17:8] == 10'd0)

endmodule

bind editing_line_input_buffer elib_checker u_elib_checker (.*);

@@ tb/sv/editing_line_input_buffer_test.sv @@
// self-checking stream testbench for the editing line input buffer
module editing_line_input_buffer_test;
    import elib_pkg::*;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [1:0] end_status;
        logic [7:0] line_length;
        logic       last;
    } line_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // in_byte[7:0], read_index[15:8]
    logic        s_axis_tuser;   // func[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // out_byte[7:0], end_status[9:8], line_length[17:10]
    logic [1:0]  m_axis_tuser;   // kind[1:0]
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    // expected echo, line end and read results, oldest first
    line_result_t line_results_q[$];
    line_result_t got_want;

    // shadow of the editor state
    logic [7:0] line_mem [0:255];
    logic [7:0] char_cnt;
    logic [8:0] valid_len;
    logic       line_done;
    logic [7:0] limit_reg;

    int err_count;
    int items_sent;
    bit idle_en;

    editing_line_input_buffer #(
        .STORE_DEPTH(256)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("editing_line_input_buffer_test failed");
        $finish;
    end

    function automatic line_result_t make_result(input logic [1:0] kind, input logic [7:0] b,
                                                 input logic [1:0] st, input logic [7:0] len);
        line_result_t r;
        r.kind        = kind;
        r.out_byte    = b;
        r.end_status  = st;
        r.line_length = len;
        r.last        = 1'b0;
        return r;
    endfunction

    // apply one request to the shadow state and queue the results it causes
    task automatic edit_and_predict(input logic func, input logic [7:0] ch,
                                    input logic [7:0] idx);
        line_result_t res[$];
        line_result_t tail;
        logic [7:0]   rd;
        if (func)
        begin
            rd = ({1'b0, idx} < valid_len) ? line_mem[idx] : 8'h00;
            res.push_back(make_result(KIND_READ, rd, ST_EOL, 8'd0));
        end
        else
        begin
            if (line_done)
            begin
                char_cnt  = 8'd0;
                valid_len = 9'd0;
                line_done = 1'b0;
            end
            if (ch == CH_BS || ch == CH_DEL)
            begin
                if (char_cnt == 8'd0)
                    res.push_back(make_result(KIND_ECHO, CH_BEL, ST_EOL, 8'd0));
                else
                begin
                    char_cnt  = char_cnt - 8'd1;
                    valid_len = {1'b0, char_cnt};
                    res.push_back(make_result(KIND_ECHO, CH_BS, ST_EOL, 8'd0));
                    res.push_back(make_result(KIND_ECHO, CH_SPACE, ST_EOL, 8'd0));
                    res.push_back(make_result(KIND_ECHO, CH_BS, ST_EOL, 8'd0));
                end
            end
            else if (ch == CH_CR || ch == CH_LF)
            begin
                line_mem[char_cnt] = ch;
                valid_len = {1'b0, char_cnt} + 9'd1;
                line_done = 1'b1;
                res.push_back(make_result(KIND_END, ch, ST_EOL, char_cnt));
            end
            else if (ch == CH_CAN)
            begin
                char_cnt  = 8'd0;
                valid_len = 9'd0;
                line_done = 1'b1;
                res.push_back(make_result(KIND_END, ch, ST_CANCEL, 8'd0));
            end
            else
            begin
                line_mem[char_cnt] = ch;
                char_cnt  = char_cnt + 8'd1;
                valid_len = {1'b0, char_cnt};
                res.push_back(make_result(KIND_ECHO, ch, ST_EOL, 8'd0));
                // full test runs after the store, so a lowered limit ends the line here
                if (char_cnt >= limit_reg)
                begin
                    line_done = 1'b1;
                    res.push_back(make_result(KIND_END, ch, ST_FULL, char_cnt));
                end
            end
        end
        tail = res.pop_back();
        tail.last = 1'b1;
        res.push_back(tail);
        foreach (res[i])
            line_results_q.push_back(res[i]);
    endtask

    task automatic send_request(input logic func, input logic [7:0] ch, input logic [7:0] idx);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {idx, ch};
        s_axis_tuser  <= func;
        do @(posedge clk); while (!s_axis_tready);
        edit_and_predict(func, ch, idx);
        items_sent++;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // unused field of each request carries random bits
    task automatic send_byte(input logic [7:0] ch);
        send_request(1'b0, ch, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_read(input logic [7:0] idx);
        send_request(1'b1, 8'($urandom_range(0, 255)), idx);
    endtask

    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        while (line_results_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_line_limit(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_reg = v;
    endtask

    function automatic logic [7:0] text_char();
        return 8'($urandom_range(8'h21, 8'h7E));
    endfunction

    // controls, reads past the line, new line after an end, default limit
    task automatic test_directed_edits();
        send_read(8'd0);
        send_read(8'hFF);
        send_byte(CH_BS);
        send_byte(CH_DEL);
        send_byte(8'h41);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h55);
        send_read(8'd0);
        send_read(8'd3);
        send_read(8'd4);
        send_byte(CH_DEL);
        send_byte(CH_BS);
        send_read(8'd1);
        send_byte(CH_CR);
        send_read(8'd2);
        send_read(8'd3);
        send_byte(8'h42);
        send_byte(CH_CAN);
        send_read(8'd0);
        send_byte(CH_LF);
        send_byte(CH_BS);
        send_byte(CH_CAN);
    endtask

    // smallest and largest limit, and a limit lowered under an open line
    task automatic test_limit_settings();
        wait_results_done();
        write_line_limit(8'd1);
        send_byte(8'h78);
        send_byte(CH_BS);
        send_byte(8'h79);
        send_read(8'd0);
        wait_results_done();
        write_line_limit(8'd255);
        repeat (5)
            send_byte(text_char());
        wait_results_done();
        write_line_limit(8'd3);
        send_byte(8'h7A);
        send_read(8'd5);
        send_read(8'd6);
    endtask

    task automatic test_random_lines(input int count);
        int stop_at;
        int len;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                wait_results_done();
                pick = $urandom_range(0, 3);
                case (pick)
                    0:       write_line_limit(8'd1);
                    1:       write_line_limit(8'd255);
                    2:       write_line_limit(8'($urandom_range(2, 12)));
                    default: write_line_limit(8'($urandom_range(1, 255)));
                endcase
            end
            len = $urandom_range(0, 16);
            repeat (len)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    send_byte((pick < 5) ? CH_BS : CH_DEL);
                else if (pick < 16)
                    send_read(8'($urandom_range(0, valid_len)));
                else if (pick < 22)
                    send_read(8'($urandom_range(0, 255)));
                else if (pick < 28)
                    send_byte(8'($urandom_range(0, 255)));
                else
                    send_byte(text_char());
            end
            pick = $urandom_range(0, 9);
            if (pick < 4)
                send_byte(CH_CR);
            else if (pick < 6)
                send_byte(CH_LF);
            else if (pick < 7)
                send_byte(CH_CAN);
            // otherwise the line stays open into the next round
        end
    endtask

    // full rate on both sides, short lines so rubouts and ends stack up
    task automatic test_back_to_back(input int count);
        int pick;
        idle_en = 1'b0;
        wait_results_done();
        write_line_limit(8'd4);
        repeat (count)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
                send_byte(CH_BS);
            else if (pick < 3)
                send_byte(CH_CR);
            else if (pick < 5)
                send_read(8'($urandom_range(0, 5)));
            else
                send_byte(text_char());
        end
    endtask

    // result sink with random stall bursts
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s expected %0h got %0h", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (line_results_q.size() == 0)
            begin
                $error("unexpected result kind %0d byte %0h", m_axis_tuser, m_axis_tdata[7:0]);
                err_count++;
            end
            else
            begin
                got_want = line_results_q.pop_front();
                check_field("kind", 8'(got_want.kind), 8'(m_axis_tuser));
                check_field("out_byte", got_want.out_byte, m_axis_tdata[7:0]);
                check_field("end_status", 8'(got_want.end_status), 8'(m_axis_tdata[9:8]));
                check_field("line_length", got_want.line_length, m_axis_tdata[17:10]);
                check_field("last", 8'(got_want.last), 8'(m_axis_tlast));
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'd0;
        s_axis_tuser  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 8'd0;
        idle_en       = 1'b1;
        err_count     = 0;
        items_sent    = 0;
        char_cnt      = 8'd0;
        valid_len     = 9'd0;
        line_done     = 1'b0;
        limit_reg     = LIMIT_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_edits();
        test_limit_settings();
        test_random_lines(145);
        test_back_to_back(30);
        wait_results_done();
        repeat (10) @(posedge clk);
        if (err_count == 0 && line_results_q.size() == 0)
            $display("editing_line_input_buffer_test passed");
        else
            $display("editing_line_input_buffer_test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/elib_pkg.sv
hw/rtl/elib_line_store.sv
hw/rtl/editing_line_input_buffer.sv
hw/rtl/elib_checker.sv
tb/sv/editing_line_input_buffer_test.sv
